[rtl/edacc_pkg.sv]
// Shared types and constants for the Euclidean distance accumulator.
// Depends on nothing; every other file of the block imports it.
package edacc_pkg;

	// Element and vector limits.
	localparam int ELEM_WIDTH = 16;
	localparam int MAX_DIM    = 1024;

	// Derived widths: difference, its magnitude, its square and the running sum.
	localparam int DIFF_W = ELEM_WIDTH + 1;
	localparam int MAG_W  = ELEM_WIDTH + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = 42;
	localparam int ROOT_W = SUM_W / 2;
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int STEP_W = $clog2(ROOT_W);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM);

	// One input beat: an element pair and the end-of-vector flag.
	typedef struct packed {
		logic signed [15:0] a_value;
		logic signed [15:0] b_value;
		logic               last_element;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [20:0] distance;
		logic        saturated;
	} out_beat_t;

	// Controls from the sequencer to the accumulator.
	typedef struct packed {
		logic load;   // capture the magnitude of a new pair's difference
		logic mul;    // square the captured magnitude
		logic acc;    // add the square into the running sum
		logic clear;  // start a new vector
	} acc_ctrl_t;

endpackage

[rtl/edacc_accum.sv]
// Sum-of-squares accumulator: difference, square and saturating running sum.
// Depends on edacc_pkg.
module edacc_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  edacc_pkg::acc_ctrl_t      ctrl,
	input  edacc_pkg::in_beat_t       beat,
	output logic [edacc_pkg::SUM_W-1:0] sum,
	output logic                      overflow
);
	import edacc_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic [MAG_W-1:0]         mag_q;
	logic [SQ_W-1:0]          sq_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         count_q;
	logic                     overflow_q;
	logic [SUM_W:0]           total;

	// Exact difference of the two sign-extended elements.
	assign diff = {beat.a_value[ELEM_WIDTH-1], beat.a_value[ELEM_WIDTH-1:0]}
		- {beat.b_value[ELEM_WIDTH-1], beat.b_value[ELEM_WIDTH-1:0]};

	// Wide sum with a carry bit that flags a clip.
	assign total = {1'b0, sum_q} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_q};

	// Magnitude and square registers; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		end
		if (ctrl.mul) begin
			sq_q <= mag_q * mag_q;
		end
	end

	// Running sum, pair count and sticky saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.clear) begin
			sum_q      <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.acc) begin
			if (count_q == CNT_MAX) begin
				sum_q      <= SUM_MAX;
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				if (total[SUM_W]) begin
					sum_q      <= SUM_MAX;
					overflow_q <= 1'b1;
				end else begin
					sum_q <= total[SUM_W-1:0];
				end
			end
		end
	end

	assign sum      = sum_q;
	assign overflow = overflow_q;

endmodule

[rtl/edacc_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on edacc_pkg.
module edacc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [edacc_pkg::SUM_W-1:0]  radicand,
	output logic                         done,
	output logic [edacc_pkg::ROOT_W-1:0] root
);
	import edacc_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  rem_diff;
	logic              fits;

	// One restoring step: bring down two radicand bits and try the next root bit.
	assign rem_sh   = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial    = {{(REM_W - ROOT_W){1'b0}}, root_q, 2'b01};
	assign rem_diff = rem_sh - trial;
	assign fits     = (rem_sh >= trial);

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Datapath registers of the root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/euclidean_distance_accumulator.sv]
// Top level of the Euclidean distance accumulator: sequencer and output register.
// Depends on edacc_pkg, edacc_accum and edacc_sqrt.
//
// Each input beat carries one signed Q8.8 element pair. For a pair that does
// not close a vector, the difference magnitude is registered, squared in the
// next cycle and then added to the 42-bit saturating sum. A pair flagged
// last_element goes on through further steps: the sum is handed to the
// square-root unit, the unit runs one iteration per bit of the 21-bit root at
// one result bit per cycle, it raises its done flag and the output register is
// loaded. The square-root loop sets the rate for the closing pair. The input is
// stalled while a pair is in work. The result sits in its own register, so the
// next vector may start while it waits to be taken; a second result waits in
// the sequencer until that register is free, adding the cycles of that wait.
module euclidean_distance_accumulator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  edacc_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output edacc_pkg::out_beat_t out_data
);
	import edacc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_START,
		S_ROOT,
		S_OUT
	} state_t;

	state_t            state_q;
	logic              last_q;
	logic              sat_q;
	logic              out_valid_q;
	out_beat_t         out_q;
	acc_ctrl_t         ctrl;
	logic              in_take;
	logic              out_free;
	logic [SUM_W-1:0]  sum;
	logic              overflow;
	logic              root_done;
	logic [ROOT_W-1:0] root;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Controls to the accumulator follow the state.
	always_comb begin
		ctrl       = '0;
		ctrl.load  = in_take;
		ctrl.mul   = (state_q == S_MUL);
		ctrl.acc   = (state_q == S_ACC);
		ctrl.clear = (state_q == S_START);
	end

	edacc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.beat     (in_data),
		.sum      (sum),
		.overflow (overflow)
	);

	edacc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.radicand (sum),
		.done     (root_done),
		.root     (root)
	);

	// Sequencer, end-of-vector flag and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// The result beat is raised on a load and dropped once taken.
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						last_q  <= in_data.last_element;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= last_q ? S_START : S_IDLE;
				end
				S_START: begin
					sat_q   <= overflow;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q   <= '{distance: root, saturated: sat_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
